// File: rtl/sole_pkg.sv
// ----------------------------------------------------------------------------
// Second-order lag element: shared package
// Register indexes, controller commands and fixed widths used across the block.
// ----------------------------------------------------------------------------
package sole_pkg;

  localparam int DIGIT_W      = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int TCONST_W     = 32;
  localparam int PERIOD_W     = 32;
  localparam int DAMP_FIELD_W = 24;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd655;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN          = 2'd0,
    REG_TIME_CONSTANT = 2'd1,
    REG_DAMPING       = 2'd2,
    REG_SAMPLE_PERIOD = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_MUL_LOAD,
    CMD_MUL_STEP,
    CMD_MUL_STORE,
    CMD_DEN_A,
    CMD_DEN_B,
    CMD_DIV_LOAD,
    CMD_DIV_STEP,
    CMD_FINISH
  } cmd_op_t;

  typedef enum logic [2:0] {
    PROD_TT,
    PROD_DT,
    PROD_DTD,
    PROD_DD,
    PROD_T1,
    PROD_T2,
    PROD_UD,
    PROD_T3
  } prod_t;

  typedef struct packed {
    cmd_op_t op;
    prod_t   prod;
  } cmd_t;

endpackage

// File: rtl/sole_if.sv
// ----------------------------------------------------------------------------
// Second-order lag element: channel interfaces
// Valid/ready channels for configuration writes, input items and result items.
// ----------------------------------------------------------------------------
interface sole_cfg_if #(parameter int DATA_W = 32) ();
  logic                              valid;
  logic                              ready;
  logic [sole_pkg::CFG_INDEX_W-1:0]  index;
  logic [DATA_W-1:0]                 data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface sole_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, sample_in, input ready);
  modport sink (input valid, sample_in, output ready);
endinterface

interface sole_out_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  logic                saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink (input valid, sample_out, saturated, output ready);
endinterface

// File: rtl/sole_ctrl.sv
// ----------------------------------------------------------------------------
// Second-order lag element: controller
// Sequences the eight digit-serial products, the denominator sum, the
// restoring division and the final rounding for each item.
// ----------------------------------------------------------------------------
module sole_ctrl #(
  parameter int SIGNAL_WIDTH = 32,
  parameter int NDIG         = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sole_pkg::cmd_t  cmd
);

  localparam int CW = $clog2(SIGNAL_WIDTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LOAD,
    S_MUL_STEP,
    S_MUL_STORE,
    S_DEN_A,
    S_DEN_B,
    S_DIV_LOAD,
    S_DIV_STEP,
    S_FINISH
  } state_t;

  state_t          state;
  sole_pkg::prod_t prod;
  sole_pkg::prod_t prod_next;
  logic [CW-1:0]   cnt;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (prod)
      sole_pkg::PROD_TT:  prod_next = sole_pkg::PROD_DT;
      sole_pkg::PROD_DT:  prod_next = sole_pkg::PROD_DTD;
      sole_pkg::PROD_DTD: prod_next = sole_pkg::PROD_DD;
      sole_pkg::PROD_DD:  prod_next = sole_pkg::PROD_T1;
      sole_pkg::PROD_T1:  prod_next = sole_pkg::PROD_T2;
      sole_pkg::PROD_T2:  prod_next = sole_pkg::PROD_UD;
      sole_pkg::PROD_UD:  prod_next = sole_pkg::PROD_T3;
      default:            prod_next = sole_pkg::PROD_TT;
    endcase
  end

  always_comb begin
    cmd.prod = prod;
    case (state)
      S_MUL_LOAD:  cmd.op = sole_pkg::CMD_MUL_LOAD;
      S_MUL_STEP:  cmd.op = sole_pkg::CMD_MUL_STEP;
      S_MUL_STORE: cmd.op = sole_pkg::CMD_MUL_STORE;
      S_DEN_A:     cmd.op = sole_pkg::CMD_DEN_A;
      S_DEN_B:     cmd.op = sole_pkg::CMD_DEN_B;
      S_DIV_LOAD:  cmd.op = sole_pkg::CMD_DIV_LOAD;
      S_DIV_STEP:  cmd.op = sole_pkg::CMD_DIV_STEP;
      S_FINISH:    cmd.op = out_free ? sole_pkg::CMD_FINISH : sole_pkg::CMD_IDLE;
      default:     cmd.op = sole_pkg::CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prod      <= sole_pkg::PROD_TT;
      cnt       <= '0;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            prod     <= sole_pkg::PROD_TT;
            state    <= S_MUL_LOAD;
          end
        end
        S_MUL_LOAD: begin
          cnt   <= '0;
          state <= S_MUL_STEP;
        end
        S_MUL_STEP: begin
          if (cnt == CW'(NDIG - 1)) begin
            state <= S_MUL_STORE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_MUL_STORE: begin
          if (prod == sole_pkg::PROD_T3) begin
            state <= S_DEN_A;
          end else begin
            prod  <= prod_next;
            state <= S_MUL_LOAD;
          end
        end
        S_DEN_A: begin
          state <= S_DEN_B;
        end
        S_DEN_B: begin
          state <= S_DIV_LOAD;
        end
        S_DIV_LOAD: begin
          cnt   <= '0;
          state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (cnt == CW'(SIGNAL_WIDTH)) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/sole_dp.sv
// ----------------------------------------------------------------------------
// Second-order lag element: datapath
// Configuration and history registers, a digit-serial multiplier, the exact
// numerator and denominator, a restoring divider and the rounding stage.
// ----------------------------------------------------------------------------
module sole_dp #(
  parameter int SIGNAL_WIDTH  = 32,
  parameter int FRACTION_BITS = 16,
  parameter int NDIG          = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [sole_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [((SIGNAL_WIDTH > 32) ? SIGNAL_WIDTH : 32)-1:0] cfg_data,
  input  logic                                  capture,
  input  logic signed [SIGNAL_WIDTH-1:0]        sample_in,
  input  sole_pkg::cmd_t                        cmd,
  output logic signed [SIGNAL_WIDTH-1:0]        sample_out,
  output logic                                  saturated
);

  localparam int SW   = SIGNAL_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int DGW  = sole_pkg::DIGIT_W;
  localparam int TW   = sole_pkg::TCONST_W;
  localparam int PERW = sole_pkg::PERIOD_W;
  localparam int DMW  = (FB + 1 > sole_pkg::DAMP_FIELD_W) ? FB + 1 : sole_pkg::DAMP_FIELD_W;
  localparam int SQW  = 2 * TW;
  localparam int DTDW = 2 * TW + DMW;
  localparam int TMPW = SQW + SW;
  localparam int AW   = (DTDW > TMPW) ? DTDW : TMPW;
  localparam int BWP  = NDIG * DGW;
  localparam int PW   = AW + BWP;
  localparam int T1W  = SQW + SW + 1 + FB;
  localparam int T2W  = DTDW + SW + 1;
  localparam int T3W  = SQW + 2 * SW;
  localparam int T12W = (T1W > T2W) ? T1W : T2W;
  localparam int TMW  = (T12W > T3W) ? T12W : T3W;
  localparam int NW   = TMW + 3;
  localparam int DWA  = (SQW + FB > DTDW + 1) ? SQW + FB : DTDW + 1;
  localparam int DW   = DWA + 2;
  localparam int RW   = (NW > DW + SW + 1) ? NW : DW + SW + 1;

  logic [SW-1:0]    gain;
  logic [TW-1:0]    tconst;
  logic [DMW-1:0]   damp;
  logic [PERW-1:0]  period;
  logic [SW-1:0]    y1;
  logic [SW-1:0]    y2;
  logic [SW-1:0]    u;

  logic [AW-1:0]    a_op;
  logic [BWP-1:0]   b_op;
  logic [PW-1:0]    prod;
  logic [SQW-1:0]   tt;
  logic [DTDW-1:0]  dtd;
  logic [SQW-1:0]   dtdt;
  logic [TMPW-1:0]  tmp;
  logic [NW-1:0]    num;
  logic [DW-1:0]    den;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    dsh;
  logic [SW:0]      quo;
  logic             neg;

  logic [SW+1:0]    lin;
  logic [SW+1:0]    lin_neg;
  logic [SW:0]      lin_mag;
  logic [SW-1:0]    y1_mag;
  logic [SW-1:0]    u_mag;
  logic [SW-1:0]    k_mag;
  logic [PERW-1:0]  dt_eff;
  logic [AW-1:0]    a_load;
  logic [BWP-1:0]   b_load;
  logic [AW+DGW-1:0] pp;
  logic [PW-1:0]    prod_step;
  logic [NW-1:0]    term;
  logic             term_neg;
  logic [NW-1:0]    num_acc;
  logic [NW-1:0]    num_mag;
  logic             ge;
  logic             round_up;
  logic [SW:0]      q_r;
  logic [SW:0]      limit;
  logic             sat_now;
  logic [SW:0]      q_f;
  logic [SW:0]      q_neg;
  logic [SW-1:0]    y_new;

  assign lin     = {y1[SW-1], y1, 1'b0} - {{2{y2[SW-1]}}, y2};
  assign lin_neg = ~lin + (SW+2)'(1);
  assign lin_mag = lin[SW+1] ? lin_neg[SW:0] : lin[SW:0];
  assign y1_mag  = y1[SW-1] ? (~y1 + SW'(1)) : y1;
  assign u_mag   = u[SW-1] ? (~u + SW'(1)) : u;
  assign k_mag   = gain[SW-1] ? (~gain + SW'(1)) : gain;
  assign dt_eff  = (period == '0) ? PERW'(1) : period;

  always_comb begin
    case (cmd.prod)
      sole_pkg::PROD_TT: begin
        a_load = AW'(tconst);
        b_load = BWP'(tconst);
      end
      sole_pkg::PROD_DT: begin
        a_load = AW'(tconst);
        b_load = BWP'(damp);
      end
      sole_pkg::PROD_DTD: begin
        a_load = AW'(dtd);
        b_load = BWP'(dt_eff);
      end
      sole_pkg::PROD_DD: begin
        a_load = AW'(dt_eff);
        b_load = BWP'(dt_eff);
      end
      sole_pkg::PROD_T1: begin
        a_load = AW'(tt);
        b_load = BWP'(lin_mag);
      end
      sole_pkg::PROD_T2: begin
        a_load = AW'(dtd);
        b_load = BWP'(y1_mag);
      end
      sole_pkg::PROD_UD: begin
        a_load = AW'(dtdt);
        b_load = BWP'(u_mag);
      end
      sole_pkg::PROD_T3: begin
        a_load = AW'(tmp);
        b_load = BWP'(k_mag);
      end
      default: begin
        a_load = '0;
        b_load = '0;
      end
    endcase
  end

  assign pp        = a_op * b_op[BWP-1 -: DGW];
  assign prod_step = (prod << DGW) + PW'(pp);

  always_comb begin
    case (cmd.prod)
      sole_pkg::PROD_T1: begin
        term     = NW'(prod) << FB;
        term_neg = lin[SW+1];
      end
      sole_pkg::PROD_T2: begin
        term     = NW'(prod) << 1;
        term_neg = y1[SW-1];
      end
      default: begin
        term     = NW'(prod);
        term_neg = u[SW-1] ^ gain[SW-1];
      end
    endcase
    num_acc = term_neg ? (num - term) : (num + term);
  end

  assign num_mag = num[NW-1] ? (~num + NW'(1)) : num;
  assign ge      = rem >= dsh;

  assign round_up = {rem, 1'b0} >= (RW+1)'(den);
  assign q_r      = quo + (SW+1)'(round_up);
  assign limit    = neg ? ((SW+1)'(1) << (SW - 1)) : (((SW+1)'(1) << (SW - 1)) - (SW+1)'(1));
  assign sat_now  = quo[SW] || (q_r > limit);
  assign q_f      = sat_now ? limit : q_r;
  assign q_neg    = ~q_f + (SW+1)'(1);
  assign y_new    = neg ? q_neg[SW-1:0] : q_f[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= SW'(1) << FB;
      tconst <= TW'(1) << FB;
      damp   <= DMW'(1) << FB;
      period <= sole_pkg::PERIOD_RESET;
      y1     <= '0;
      y2     <= '0;
    end else begin
      if (cfg_write) begin
        case (sole_pkg::reg_index_t'(cfg_index))
          sole_pkg::REG_GAIN:          gain   <= cfg_data[SW-1:0];
          sole_pkg::REG_TIME_CONSTANT: tconst <= cfg_data[TW-1:0];
          sole_pkg::REG_DAMPING:       damp   <= DMW'(cfg_data[sole_pkg::DAMP_FIELD_W-1:0]);
          sole_pkg::REG_SAMPLE_PERIOD: period <= cfg_data[PERW-1:0];
          default: ;
        endcase
      end
      if (cmd.op == sole_pkg::CMD_FINISH) begin
        y2 <= y1;
        y1 <= y_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      u   <= sample_in;
      num <= '0;
    end
    case (cmd.op)
      sole_pkg::CMD_MUL_LOAD: begin
        a_op <= a_load;
        b_op <= b_load;
        prod <= '0;
      end
      sole_pkg::CMD_MUL_STEP: begin
        prod <= prod_step;
        b_op <= b_op << DGW;
      end
      sole_pkg::CMD_MUL_STORE: begin
        case (cmd.prod)
          sole_pkg::PROD_TT:  tt   <= prod[SQW-1:0];
          sole_pkg::PROD_DT:  dtd  <= prod[DTDW-1:0];
          sole_pkg::PROD_DTD: dtd  <= prod[DTDW-1:0];
          sole_pkg::PROD_DD:  dtdt <= prod[SQW-1:0];
          sole_pkg::PROD_UD:  tmp  <= prod[TMPW-1:0];
          default:            num  <= num_acc;
        endcase
      end
      sole_pkg::CMD_DEN_A: begin
        den <= (DW'(tt) << FB) + (DW'(dtdt) << FB);
      end
      sole_pkg::CMD_DEN_B: begin
        den <= den + (DW'(dtd) << 1);
      end
      sole_pkg::CMD_DIV_LOAD: begin
        neg <= num[NW-1];
        rem <= RW'(num_mag);
        dsh <= RW'(den) << SW;
        quo <= '0;
      end
      sole_pkg::CMD_DIV_STEP: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo <= {quo[SW-1:0], ge};
        dsh <= dsh >> 1;
      end
      sole_pkg::CMD_FINISH: begin
        sample_out <= y_new;
        saturated  <= sat_now;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/second_order_lag_element.sv
// ----------------------------------------------------------------------------
// Second-order lag element
// Fixed-point PT2 plant, backward-Euler form, one result item per input item.
//
// Each input item u gives y = ((2*y1 - y2)*T^2 + 2*dt*y1*D*T + dt^2*u*K) /
// (T^2 + 2*dt*D*T + dt^2), formed exactly, rounded to nearest with ties away
// from zero and saturated to SIGNAL_WIDTH signed bits; saturated marks a
// clipped result, and the history keeps the clipped value. A sample period of
// zero counts as one LSB. Eight products are formed one 8-bit digit per cycle
// in a shared multiplier, over NDIG digits, where NDIG =
// ceil(max(32, SIGNAL_WIDTH+1)/8), and the restoring divider yields one
// quotient bit per cycle. The next item is taken as soon as the result
// sits in the output register, even while that result waits.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module second_order_lag_element #(
  parameter int SIGNAL_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  sole_cfg_if.sink     cfg,
  sole_in_if.sink      plant_in,
  sole_out_if.source   plant_out
);

  localparam int BW   = (SIGNAL_WIDTH + 1 > 32) ? SIGNAL_WIDTH + 1 : 32;
  localparam int NDIG = (BW + sole_pkg::DIGIT_W - 1) / sole_pkg::DIGIT_W;

  sole_pkg::cmd_t cmd;
  logic           in_fire;

  assign cfg.ready = 1'b1;
  assign in_fire   = plant_in.valid && plant_in.ready;

  sole_ctrl #(
    .SIGNAL_WIDTH (SIGNAL_WIDTH),
    .NDIG         (NDIG)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (plant_in.valid),
    .in_ready  (plant_in.ready),
    .out_valid (plant_out.valid),
    .out_ready (plant_out.ready),
    .cmd       (cmd)
  );

  sole_dp #(
    .SIGNAL_WIDTH  (SIGNAL_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .NDIG          (NDIG)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .capture    (in_fire),
    .sample_in  (plant_in.sample_in),
    .cmd        (cmd),
    .sample_out (plant_out.sample_out),
    .saturated  (plant_out.saturated)
  );

  a_ready_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    plant_in.ready |-> cmd.op == sole_pkg::CMD_IDLE)
    else $error("input ready while a computation is in progress");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !plant_in.ready)
    else $error("input still ready after an item was accepted");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(plant_out.valid) |-> $past(cmd.op == sole_pkg::CMD_FINISH))
    else $error("result shown without a finishing step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == sole_pkg::CMD_FINISH |-> (!plant_out.valid || plant_out.ready))
    else $error("result register loaded while a result is still pending");

endmodule
